// File: hdl/bollinger_band_swing_signal_unit_assert.svh
`ifndef BOLLINGER_BAND_SWING_SIGNAL_UNIT_ASSERT_SVH
`define BOLLINGER_BAND_SWING_SIGNAL_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define BBS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BBS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hdl/bbs_pkg.sv
package bbs_pkg;
    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_BITS_DEF = 24;
    localparam int CFG_IDX_BITS   = 1;
    localparam int CFG_DATA_BITS  = 12;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAND_MULT     = 1'd1;
    localparam logic [6:0]  LEN_RESET  = 7'd20;
    localparam logic [11:0] MULT_RESET = 12'd512;
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_BUY  = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;
    localparam int OUT_BITS = 1 + 32 + 36 + 2 + 25 + 48 + 1;
    localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;
endpackage

// File: hdl/bbs_ram.sv
module bbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/bollinger_band_swing_signal_unit.sv
// Once the window is full, each price passes through the bit-serial square root and the two
// bit-serial dividers (mean, deviation); while the window fills, these are skipped. A new
// price is taken only in the idle state, after the previous result has been loaded into the
// output register. A finished result waits in that output register, so the next item is
// worked while the receiver holds off.
// Reset (aresetn low, synchronous) empties the window, clears position and total.
module bollinger_band_swing_signal_unit #(
    parameter int MAX_WINDOW = bbs_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = bbs_pkg::PRICE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [bbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bbs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // close_price
    input  logic [((PRICE_BITS+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // band_ready, moving_average, band_half_width, trade_signal, trade_profit,
    // total_profit, position_open
    output logic [bbs_pkg::OUT_BYTES_BITS-1:0] m_tdata
);
    import bbs_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int SW = PRICE_BITS + LW;
    localparam int QW = 2 * PRICE_BITS + LW;
    localparam int NW = QW + LW;
    localparam int RW = NW / 2 + 8;
    localparam int IW = $clog2(RW + SW + 9);
    localparam logic [LW-1:0] MAXW = LW'(MAX_WINDOW);

    localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_UPD = 4'd2, ST_MUL = 4'd3,
        ST_NUM = 4'd4, ST_SQRT = 4'd5, ST_DIVM = 4'd6, ST_DIVS = 4'd7, ST_HALF = 4'd8,
        ST_DEC = 4'd9, ST_OUT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [6:0] wlen_reg;
    logic [11:0] mult_reg;
    logic [LW-1:0] len_reg, fill_reg;
    logic [AW-1:0] wptr_reg;
    logic [SW-1:0] sum_reg;
    logic [QW-1:0] sq_reg;
    logic hold_reg;
    logic [PRICE_BITS-1:0] entry_reg, price_reg, old_data;
    logic signed [47:0] total_reg;
    logic [NW-1:0] num_reg;
    logic [RW-1:0] root_reg;
    logic [RW+1:0] rem_reg;
    logic [SW+8:0] dq_reg;
    logic [LW:0] drem_reg;
    logic [IW-1:0] cnt_reg;
    logic [31:0] mean_reg;
    logic [35:0] half_reg;
    logic [RW-1:0] sd_reg;
    logic [1:0] sig_reg;
    logic signed [24:0] prof_reg;
    logic ready_reg, full_reg, drop_reg;
    logic [2*PRICE_BITS-1:0] psq_reg, osq_reg;
    logic [OUT_BITS-1:0] obuf_reg;
    logic ovalid_reg;

    logic [PRICE_BITS-1:0] in_price;
    logic [LW-1:0] eff_len;
    logic ram_we;
    logic out_go;

    assign in_price = s_tdata[PRICE_BITS-1:0];
    assign eff_len = (wlen_reg == 7'd0) ? LW'(1) :
                     ({25'd0, wlen_reg} > 32'(MAX_WINDOW)) ? MAXW : LW'(wlen_reg);
    assign s_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign ram_we = (state_reg == ST_UPD);
    assign out_go = (state_reg == ST_OUT) && (!ovalid_reg || m_tready);

    bbs_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_WINDOW)) u_ram (
        .aclk (aclk), .we (ram_we), .waddr (wptr_reg), .wdata (price_reg),
        .raddr (wptr_reg), .rdata (old_data)
    );

    logic [RW+1:0] trial;
    logic [RW+1:0] rsh;
    logic [1:0] pair;
    logic [LW:0] dsh;
    logic [47:0] mh;
    logic [PRICE_BITS+8:0] pq;
    logic signed [48:0] tsum;

    always_comb begin
        pair = num_reg[NW-1 -: 2];
        rsh = {rem_reg[RW-1:0], pair};
        trial = {root_reg, 2'b01};
        dsh = {drem_reg[LW-1:0], dq_reg[SW+8]};
        mh = 48'(mean_reg) + 48'(half_reg);
        pq = {1'b0, price_reg, 8'd0};
        tsum = 49'(total_reg) + 49'(prof_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_RD;
            ST_RD:   state_next = ST_UPD;
            ST_UPD:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_NUM;
            ST_NUM:  state_next = full_reg ? ST_SQRT : ST_OUT;
            ST_SQRT: if (cnt_reg == IW'(RW - 1)) state_next = ST_DIVM;
            ST_DIVM: if (cnt_reg == IW'(SW + 8)) state_next = ST_DIVS;
            ST_DIVS: if (cnt_reg == IW'(RW - 1)) state_next = ST_HALF;
            ST_HALF: state_next = ST_DEC;
            ST_DEC:  state_next = ST_OUT;
            ST_OUT:  if (out_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wlen_reg <= LEN_RESET;
            mult_reg <= MULT_RESET;
            fill_reg <= '0;
            wptr_reg <= '0;
            sum_reg <= '0;
            sq_reg <= '0;
            hold_reg <= 1'b0;
            entry_reg <= '0;
            total_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_go) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WINDOW_LENGTH) begin
                    wlen_reg <= cfg_data[6:0];
                    fill_reg <= '0;
                    wptr_reg <= '0;
                    sum_reg <= '0;
                    sq_reg <= '0;
                end else if (cfg_index == REG_BAND_MULT) begin
                    mult_reg <= cfg_data;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        price_reg <= in_price;
                        len_reg <= eff_len;
                        if ({{(32-AW){1'b0}}, wptr_reg} >= 32'(eff_len)) wptr_reg <= '0;
                    end
                end
                ST_RD: begin
                    psq_reg <= price_reg * price_reg;
                end
                ST_UPD: begin
                    osq_reg <= old_data * old_data;
                    drop_reg <= (fill_reg >= len_reg);
                    if (fill_reg >= len_reg) begin
                        sum_reg <= sum_reg - SW'(old_data) + SW'(price_reg);
                    end else begin
                        sum_reg <= sum_reg + SW'(price_reg);
                        fill_reg <= fill_reg + 1'b1;
                    end
                    wptr_reg <= ({{(32-AW){1'b0}}, wptr_reg} + 1 >= 32'(len_reg)) ? '0 :
                                wptr_reg + 1'b1;
                    full_reg <= (fill_reg >= len_reg) || (fill_reg + 1'b1 == len_reg);
                end
                ST_MUL: begin
                    sq_reg <= sq_reg + QW'(psq_reg) - (drop_reg ? QW'(osq_reg) : QW'(0));
                end
                ST_NUM: begin
                    cnt_reg <= '0;
                    root_reg <= '0;
                    rem_reg <= '0;
                    ready_reg <= full_reg;
                    sig_reg <= SIG_NONE;
                    prof_reg <= '0;
                    mean_reg <= '0;
                    half_reg <= '0;
                    num_reg <= full_reg ? NW'(len_reg * sq_reg) - NW'(sum_reg * sum_reg) : '0;
                    dq_reg <= {1'b0, sum_reg, 8'd0};
                    drem_reg <= '0;
                end
                ST_SQRT: begin
                    num_reg <= num_reg << 2;
                    if (rsh >= trial) begin
                        rem_reg <= rsh - trial;
                        root_reg <= {root_reg[RW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rsh;
                        root_reg <= {root_reg[RW-2:0], 1'b0};
                    end
                    cnt_reg <= (cnt_reg == IW'(RW - 1)) ? '0 : cnt_reg + 1'b1;
                end
                ST_DIVM: begin
                    if (dsh >= {1'b0, len_reg}) begin
                        drem_reg <= dsh - {1'b0, len_reg};
                        dq_reg <= {dq_reg[SW+7:0], 1'b1};
                    end else begin
                        drem_reg <= dsh;
                        dq_reg <= {dq_reg[SW+7:0], 1'b0};
                    end
                    if (cnt_reg == IW'(SW + 8)) begin
                        cnt_reg <= '0;
                        sd_reg <= root_reg;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIVS: begin
                    if (cnt_reg == '0) begin
                        mean_reg <= 32'(dq_reg);
                    end
                    if ((cnt_reg == '0 ? {{LW{1'b0}}, sd_reg[RW-1]}
                         : {drem_reg[LW-1:0], sd_reg[RW-1]}) >= {1'b0, len_reg}) begin
                        drem_reg <= (cnt_reg == '0 ? {{LW{1'b0}}, sd_reg[RW-1]}
                                     : {drem_reg[LW-1:0], sd_reg[RW-1]}) - {1'b0, len_reg};
                        sd_reg <= {sd_reg[RW-2:0], 1'b1};
                    end else begin
                        drem_reg <= (cnt_reg == '0 ? {{LW{1'b0}}, sd_reg[RW-1]}
                                     : {drem_reg[LW-1:0], sd_reg[RW-1]});
                        sd_reg <= {sd_reg[RW-2:0], 1'b0};
                    end
                    cnt_reg <= (cnt_reg == IW'(RW - 1)) ? '0 : cnt_reg + 1'b1;
                end
                ST_HALF: begin
                    half_reg <= 36'((48'(mult_reg) * 48'(sd_reg)) >> 8);
                end
                ST_DEC: begin
                    if (!hold_reg && (48'(pq) + 48'(half_reg) < 48'(mean_reg))) begin
                        sig_reg <= SIG_BUY;
                        hold_reg <= 1'b1;
                        entry_reg <= price_reg;
                    end else if (hold_reg && 48'(pq) > mh) begin
                        sig_reg <= SIG_SELL;
                        prof_reg <= 25'($signed({1'b0, price_reg}) - $signed({1'b0, entry_reg}));
                        hold_reg <= 1'b0;
                    end
                end
                ST_OUT: begin
                    if (out_go && sig_reg == SIG_SELL) begin
                        if (tsum > 49'sh7FFFFFFFFFFF) total_reg <= 48'sh7FFFFFFFFFFF;
                        else if (tsum < -49'sh800000000000) total_reg <= 48'sh800000000000;
                        else total_reg <= tsum[47:0];
                    end
                end
                default: ;
            endcase
        end
    end

    logic signed [47:0] total_out;
    assign total_out = (sig_reg != SIG_SELL) ? total_reg :
                       (tsum > 49'sh7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF :
                       (tsum < -49'sh800000000000) ? 48'sh800000000000 : tsum[47:0];

    always_ff @(posedge aclk) begin
        if (out_go) begin
            obuf_reg <= {hold_reg, total_out, prof_reg, sig_reg, half_reg,
                         mean_reg, ready_reg};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = OUT_BYTES_BITS'(obuf_reg);
endmodule

// File: hdl/bbs_checker.sv
module bbs_props (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [bbs_pkg::OUT_BYTES_BITS-1:0] m_tdata
);
    `include "bollinger_band_swing_signal_unit_assert.svh"
    `BBS_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `BBS_ASSERT_NXT(a_seq, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BBS_ASSERT_IMP(a_sig, aclk, aresetn, m_tvalid, m_tdata[70:69] != 2'd3)
    `BBS_ASSERT_IMP(a_idle, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[70:1] == '0)
endmodule

bind bollinger_band_swing_signal_unit bbs_props u_props (.*);

// File: bench/bbs_checker.sv
module bbs_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [bbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bbs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bbs_pkg::OUT_BYTES_BITS-1:0] m_tdata,
    output int                                fail_count,
    output int                                pending_count
);
    import bbs_pkg::*;

    localparam longint signed PROFIT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint signed PROFIT_MIN = -PROFIT_MAX - 1;

    typedef struct packed {
        logic        position_open;
        logic [47:0] total_profit;
        logic [24:0] trade_profit;
        logic [1:0]  trade_signal;
        logic [35:0] band_half_width;
        logic [31:0] moving_average;
        logic        band_ready;
    } band_result_t;

    logic [23:0]       price_ring [64];
    int unsigned       prices_held;
    int unsigned       ring_slot;
    longint unsigned   price_sum;
    longint unsigned   square_sum;
    logic              long_held;
    longint unsigned   buy_price;
    longint signed     running_total;
    logic [6:0]        len_reg;
    logic [11:0]       mult_reg;
    band_result_t      awaited [$];

    function automatic longint unsigned scaled_root(longint unsigned num);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        longint unsigned pair;
        root = 0;
        rem = 0;
        for (int i = 0; i < 40; i++) begin
            pair = (i < 32) ? ((num >> (62 - 2 * i)) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic int unsigned window_size();
        if (len_reg == 0) return 1;
        if (len_reg > 64) return 64;
        return len_reg;
    endfunction

    task automatic predict_band(input logic [23:0] price, output band_result_t res);
        int unsigned     len;
        longint unsigned p;
        longint unsigned old;
        longint unsigned num;
        longint unsigned dev;
        longint unsigned mean;
        longint unsigned half;
        longint signed   profit;
        logic [1:0]      sig;
        logic            full;
        len = window_size();
        p = price;
        mean = 0;
        half = 0;
        profit = 0;
        sig = SIG_NONE;
        if (ring_slot >= len) ring_slot = 0;
        if (prices_held >= len) begin
            old = price_ring[ring_slot];
            price_sum -= old;
            square_sum -= old * old;
        end
        price_ring[ring_slot] = price;
        price_sum += p;
        square_sum += p * p;
        ring_slot = (ring_slot + 1 >= len) ? 0 : ring_slot + 1;
        if (prices_held < len) prices_held++;
        full = (prices_held == len);
        if (full) begin
            num = longint'(len) * square_sum - price_sum * price_sum;
            dev = scaled_root(num) / len;
            mean = (price_sum << 8) / len;
            half = (longint'(mult_reg) * dev) >> 8;
            if (!long_held && (p << 8) + half < mean) begin
                sig = SIG_BUY;
                long_held = 1'b1;
                buy_price = p;
            end else if (long_held && (p << 8) > mean + half) begin
                sig = SIG_SELL;
                profit = longint'(p) - longint'(buy_price);
                if (profit > 0 && running_total > PROFIT_MAX - profit)
                    running_total = PROFIT_MAX;
                else if (profit < 0 && running_total < PROFIT_MIN - profit)
                    running_total = PROFIT_MIN;
                else
                    running_total += profit;
                long_held = 1'b0;
            end
        end
        res.band_ready      = full;
        res.moving_average  = mean[31:0];
        res.band_half_width = half[35:0];
        res.trade_signal    = sig;
        res.trade_profit    = profit[24:0];
        res.total_profit    = running_total[47:0];
        res.position_open   = long_held;
    endtask

    task automatic compare_field(string label, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            fail_count++;
        end
    endtask

    assign pending_count = awaited.size();

    always @(posedge aclk) begin
        band_result_t want;
        band_result_t got;
        if (!aresetn) begin
            prices_held = 0;
            ring_slot = 0;
            price_sum = 0;
            square_sum = 0;
            long_held = 1'b0;
            buy_price = 0;
            running_total = 0;
            len_reg = LEN_RESET;
            mult_reg = MULT_RESET;
            awaited.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_WINDOW_LENGTH) begin
                    len_reg = cfg_data[6:0];
                    prices_held = 0;
                    ring_slot = 0;
                    price_sum = 0;
                    square_sum = 0;
                end else if (cfg_index == REG_BAND_MULT) begin
                    mult_reg = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_band(s_tdata, want);
                awaited = {awaited, want};
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(band_result_t)-1:0];
                if (awaited.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = awaited.pop_front();
                    compare_field("band_ready", want.band_ready, got.band_ready);
                    compare_field("moving_average", want.moving_average, got.moving_average);
                    compare_field("band_half_width", want.band_half_width,
                                  got.band_half_width);
                    compare_field("trade_signal", want.trade_signal, got.trade_signal);
                    compare_field("trade_profit", want.trade_profit, got.trade_profit);
                    compare_field("total_profit", want.total_profit, got.total_profit);
                    compare_field("position_open", want.position_open, got.position_open);
                end
            end
        end
    end

    initial fail_count = 0;
endmodule

// File: bench/tb.sv
module tb;
    import bbs_pkg::*;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [23:0]                s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [OUT_BYTES_BITS-1:0]  m_tdata;
    int                         fail_count;
    int                         pending_count;
    logic                       stimulus_done;
    int unsigned                price_level;
    logic [11:0]                lengths [10] = '{2, 1, 0, 127, 64, 5, 10, 3, 20, 7};
    logic [11:0]                mults   [10] = '{0, 4095, 256, 512, 300, 128, 512, 64, 512,
                                                 4095};

    bollinger_band_swing_signal_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    bbs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic int unsigned gap_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 150);
    endfunction

    task automatic send_price(input logic [23:0] price);
        int unsigned gap;
        s_tdata = price;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [23:0] next_price();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return 24'($urandom);
        if (roll < 3) price_level = $urandom_range(1000, 16000000);
        else if (roll < 5) return 24'(price_level - $urandom_range(100, 900));
        else if (roll < 7) return 24'(price_level + $urandom_range(100, 900));
        return 24'(price_level + $urandom_range(0, 40) - 20);
    endfunction

    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if ($urandom_range(0, 299) == 0) begin
                m_tready = 1'b0;
                repeat (600) @(negedge aclk);
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat (gap_length()) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WINDOW_LENGTH;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        stimulus_done = 1'b0;
        price_level = 5000;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        repeat (25) send_price(24'($urandom_range(4000, 6000)));
        write_reg(REG_WINDOW_LENGTH, 12'd2);
        write_reg(REG_BAND_MULT, 12'd0);
        send_price(24'd100);
        send_price(24'd100);
        send_price(24'd50);
        send_price(24'hFFFFFF);
        send_price(24'd0);
        send_price(24'd0);
        send_price(24'hFFFFFF);
        send_price(24'hFFFFFF);
        send_price(24'd0);
        send_price(24'hFFFFFF);
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_WINDOW_LENGTH, lengths[ph]);
            write_reg(REG_BAND_MULT, mults[ph]);
            repeat (80) send_price(next_price());
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        while (pending_count != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("Some tests failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/bbs_pkg.sv
hdl/bbs_ram.sv
hdl/bollinger_band_swing_signal_unit.sv
hdl/bbs_checker.sv
bench/bbs_checker.sv
bench/tb.sv
